### hw/rtl/bpa_pkg.sv
// Shared types, codes and address helpers for the buddy page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int PAGE_W   = 16;
  localparam int RANK_W   = 5;
  localparam int CNT_W    = 17;
  localparam int TOP_RANK = 16;
  localparam int ROW_BITS = 64;
  localparam int ROW_AW   = 12;
  localparam int BIT_W    = 6;
  localparam int MAX_PAGES = 65536;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [ROW_AW-1:0]   rowa_t;
  typedef logic [BIT_W-1:0]    bitpos_t;

  typedef struct packed {
    logic  busy;
    rank_t rank;
  } meta_t;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_COUNT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // first free-map row of each rank; ranks 11 and up fit in one row each
  function automatic rowa_t row_base(rank_t r);
    rowa_t b;
    case (r)
      5'd1:    b = 12'd0;
      5'd2:    b = 12'd1024;
      5'd3:    b = 12'd1536;
      5'd4:    b = 12'd1792;
      5'd5:    b = 12'd1920;
      5'd6:    b = 12'd1984;
      5'd7:    b = 12'd2016;
      5'd8:    b = 12'd2032;
      5'd9:    b = 12'd2040;
      5'd10:   b = 12'd2044;
      5'd11:   b = 12'd2046;
      5'd12:   b = 12'd2047;
      5'd13:   b = 12'd2048;
      5'd14:   b = 12'd2049;
      5'd15:   b = 12'd2050;
      5'd16:   b = 12'd2051;
      default: b = 12'd0;
    endcase
    return b;
  endfunction

  function automatic cnt_t rank_size(rank_t r);
    return cnt_t'(1) << (r - 5'd1);
  endfunction

  function automatic rowa_t fm_row(rank_t r, page_t p);
    page_t blk;
    blk = p >> (r - 5'd1);
    return row_base(r) + ROW_AW'(blk >> BIT_W);
  endfunction

  function automatic bitpos_t fm_bit(rank_t r, page_t p);
    page_t blk;
    blk = p >> (r - 5'd1);
    return blk[BIT_W-1:0];
  endfunction

endpackage

### hw/rtl/bpa_ram.sv
// Single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module bpa_ram #(
  parameter int AW = 16,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

### hw/rtl/buddy_page_allocator.sv
// Buddy page allocator: sequencer over a page-metadata RAM and a free-map RAM.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+--------------------------
//  request | in_command, in_rank, in_page                 | start && !busy
//  result  | out_status, out_alloc_page, out_block_rank,  | out_valid, one cycle
//          | out_free_count                               |
//  config  | cfg_pool_pages                               | cfg_valid && cfg_ready
//
// One request at a time; each free-map bit update is a read, then a write next cycle.
// count, bad arguments, no space for alloc: the result follows in the next cycle.
// query: tries ranks 1 to 16 in turn. free: merges with free buddies level by level.
// alloc: scans 64-bit free-map rows of the chosen rank, then splits level by level.
// After reset and after each pool write, a clearing pass wipes both RAMs, then the pool
// is carved into the largest aligned blocks that fit; busy stays high throughout.
// The receiver cannot stall results.
`timescale 1ns / 1ps
module buddy_page_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  bpa_pkg::rank_t       in_rank,
  input  bpa_pkg::page_t       in_page,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output bpa_pkg::page_t       out_alloc_page,
  output bpa_pkg::rank_t       out_block_rank,
  output bpa_pkg::cnt_t        out_free_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  bpa_pkg::cnt_t        cfg_pool_pages
);
  import bpa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_CARVE  = 4'd2;
  localparam logic [3:0] S_MAP_WR = 4'd3;
  localparam logic [3:0] S_A_RD   = 4'd4;
  localparam logic [3:0] S_A_CHK  = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_F_CHK  = 4'd7;
  localparam logic [3:0] S_F_LOOP = 4'd8;
  localparam logic [3:0] S_F_BUD  = 4'd9;
  localparam logic [3:0] S_F_DONE = 4'd10;
  localparam logic [3:0] S_Q      = 4'd11;
  localparam logic [3:0] S_Q_CHK  = 4'd12;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;
  cnt_t       pool_len_r, pool_len_nxt;
  cnt_t       i_r, i_nxt;
  page_t      clr_r, clr_nxt;
  rank_t      rank_r, rank_nxt, r_r, r_nxt, mrank_r, mrank_nxt;
  page_t      page_r, page_nxt, idx_r, idx_nxt;
  rowa_t      rowptr_r, rowptr_nxt, mrow_r, mrow_nxt;
  bitpos_t    mbit_r, mbit_nxt;
  logic       mset_r, mset_nxt;
  cnt_t       fcnt_r [TOP_RANK];

  logic       out_valid_r;
  logic [1:0] out_status_r;
  page_t      out_alloc_page_r;
  rank_t      out_block_rank_r;
  cnt_t       out_free_count_r;

  logic       done;
  logic [1:0] st;
  page_t      ap;
  rank_t      br;
  cnt_t       fc;
  logic       cnt_inc, cnt_dec, cnt_clr;
  logic [3:0] cnt_idx;

  logic       meta_we;
  page_t      meta_addr;
  logic [5:0] meta_wdata, meta_rdata;
  logic       map_we;
  rowa_t      map_addr;
  row_t       map_wdata, map_rdata;
  meta_t      md;

  // parallel helpers
  logic       rank_bad, fnd;
  rank_t      fr, best;
  bitpos_t    lowbit;
  page_t      bud, qstart, sz16, rn_pg;
  rank_t      rn;
  rowa_t      off;

  bpa_ram #(.AW(PAGE_W), .DW(RANK_W + 1)) u_meta (
    .clk(clk), .we(meta_we), .addr(meta_addr), .wdata(meta_wdata), .rdata(meta_rdata)
  );

  bpa_ram #(.AW(ROW_AW), .DW(ROW_BITS)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rdata)
  );

  assign md = meta_t'(meta_rdata);

  always_comb begin
    rank_bad = (in_rank == 5'd0) || (in_rank > RANK_W'(TOP_RANK));
    fnd = 1'b0;
    fr  = 5'd0;
    for (int k = TOP_RANK - 1; k >= 0; k--) begin
      if ((RANK_W'(k + 1) >= in_rank) && (fcnt_r[k] != '0)) begin
        fnd = 1'b1;
        fr  = RANK_W'(k + 1);
      end
    end
    // largest aligned block that still fits
    best = 5'd1;
    for (int k = 1; k <= TOP_RANK; k++) begin
      if (((i_r & (rank_size(RANK_W'(k)) - cnt_t'(1))) == '0) &&
          (i_r + rank_size(RANK_W'(k)) <= pool_len_r)) begin
        best = RANK_W'(k);
      end
    end
    lowbit = '0;
    for (int k = ROW_BITS - 1; k >= 0; k--) begin
      if (map_rdata[k]) lowbit = BIT_W'(k);
    end
    sz16   = PAGE_W'(rank_size(r_r));
    bud    = idx_r ^ sz16;
    qstart = page_r & ~(sz16 - 16'd1);
    rn     = r_r - 5'd1;
    rn_pg  = idx_r + PAGE_W'(rank_size(rn));
    off    = rowptr_r - row_base(r_r);
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    pool_len_nxt = pool_len_r;
    i_nxt        = i_r;
    clr_nxt      = clr_r;
    rank_nxt     = rank_r;
    r_nxt        = r_r;
    page_nxt     = page_r;
    idx_nxt      = idx_r;
    rowptr_nxt   = rowptr_r;
    mrow_nxt     = mrow_r;
    mbit_nxt     = mbit_r;
    mrank_nxt    = mrank_r;
    mset_nxt     = mset_r;
    meta_we      = 1'b0;
    meta_addr    = idx_r;
    meta_wdata   = '0;
    map_we       = 1'b0;
    map_addr     = mrow_r;
    map_wdata    = map_rdata;
    done         = 1'b0;
    st           = ST_OK;
    ap           = '0;
    br           = '0;
    fc           = '0;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    cnt_clr      = 1'b0;
    cnt_idx      = 4'(r_r - 5'd1);

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          pool_len_nxt = (cfg_pool_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                              : cfg_pool_pages;
          clr_nxt   = '0;
          cnt_clr   = 1'b1;
          state_nxt = S_CLR;
        end else if (start) begin
          rank_nxt = in_rank;
          page_nxt = in_page;
          case (in_command)
            CMD_ALLOC: begin
              if (rank_bad) begin
                done = 1'b1;
                st   = ST_INVALID;
              end else if ((pool_len_r == '0) || !fnd) begin
                done = 1'b1;
                st   = ST_NOSPACE;
              end else begin
                r_nxt      = fr;
                rowptr_nxt = row_base(fr);
                state_nxt  = S_A_RD;
              end
            end
            CMD_FREE: begin
              if ({1'b0, in_page} >= pool_len_r) begin
                done = 1'b1;
                st   = ST_INVALID;
              end else begin
                meta_addr = in_page;
                state_nxt = S_F_CHK;
              end
            end
            CMD_QUERY: begin
              if ({1'b0, in_page} >= pool_len_r) begin
                done = 1'b1;
                st   = ST_INVALID;
              end else begin
                r_nxt     = 5'd1;
                state_nxt = S_Q;
              end
            end
            default: begin
              done = 1'b1;
              if (rank_bad) begin
                st = ST_INVALID;
              end else if (pool_len_r != '0) begin
                fc = fcnt_r[4'(in_rank - 5'd1)];
              end
            end
          endcase
        end
      end
      S_CLR: begin
        meta_we   = 1'b1;
        meta_addr = clr_r;
        map_we    = 1'b1;
        map_addr  = clr_r[ROW_AW-1:0];
        map_wdata = '0;
        clr_nxt   = clr_r + 16'd1;
        if (clr_r == '1) begin
          i_nxt     = '0;
          state_nxt = S_CARVE;
        end
      end
      S_CARVE: begin
        if (i_r >= pool_len_r) begin
          state_nxt = S_IDLE;
        end else begin
          meta_we    = 1'b1;
          meta_addr  = i_r[PAGE_W-1:0];
          meta_wdata = {1'b0, best};
          map_addr   = fm_row(best, i_r[PAGE_W-1:0]);
          mrow_nxt   = fm_row(best, i_r[PAGE_W-1:0]);
          mbit_nxt   = fm_bit(best, i_r[PAGE_W-1:0]);
          mrank_nxt  = best;
          mset_nxt   = 1'b1;
          ret_nxt    = S_CARVE;
          state_nxt  = S_MAP_WR;
          i_nxt      = i_r + rank_size(best);
        end
      end
      S_MAP_WR: begin
        map_we   = 1'b1;
        map_addr = mrow_r;
        cnt_idx  = 4'(mrank_r - 5'd1);
        if (mset_r) begin
          map_wdata = map_rdata | (row_t'(1) << mbit_r);
          cnt_inc   = 1'b1;
        end else begin
          map_wdata = map_rdata & ~(row_t'(1) << mbit_r);
          cnt_dec   = 1'b1;
        end
        state_nxt = ret_r;
      end
      S_A_RD: begin
        map_addr  = rowptr_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (map_rdata != '0) begin
          map_we    = 1'b1;
          map_addr  = rowptr_r;
          map_wdata = map_rdata & ~(row_t'(1) << lowbit);
          cnt_dec   = 1'b1;
          idx_nxt   = page_t'({off[9:0], lowbit}) << (r_r - 5'd1);
          state_nxt = S_SPLIT;
        end else begin
          rowptr_nxt = rowptr_r + 12'd1;
          state_nxt  = S_A_RD;
        end
      end
      S_SPLIT: begin
        meta_we = 1'b1;
        if (r_r > rank_r) begin
          // upper half of the split goes back free
          meta_addr  = rn_pg;
          meta_wdata = {1'b0, rn};
          map_addr   = fm_row(rn, rn_pg);
          mrow_nxt   = fm_row(rn, rn_pg);
          mbit_nxt   = fm_bit(rn, rn_pg);
          mrank_nxt  = rn;
          mset_nxt   = 1'b1;
          ret_nxt    = S_SPLIT;
          r_nxt      = rn;
          state_nxt  = S_MAP_WR;
        end else begin
          meta_addr  = idx_r;
          meta_wdata = {1'b1, rank_r};
          done       = 1'b1;
          ap         = idx_r;
          state_nxt  = S_IDLE;
        end
      end
      S_F_CHK: begin
        if ((md.rank == '0) || !md.busy) begin
          done      = 1'b1;
          st        = ST_INVALID;
          state_nxt = S_IDLE;
        end else begin
          meta_we   = 1'b1;
          meta_addr = page_r;
          idx_nxt   = page_r;
          r_nxt     = md.rank;
          state_nxt = S_F_LOOP;
        end
      end
      S_F_LOOP, S_F_BUD: begin
        if ((state_r == S_F_LOOP) && (r_r < RANK_W'(TOP_RANK)) &&
            ({1'b0, bud} + rank_size(r_r) <= pool_len_r)) begin
          meta_addr = bud;
          state_nxt = S_F_BUD;
        end else if ((state_r == S_F_BUD) && (md.rank == r_r) && !md.busy) begin
          // buddy is free: take it off its list and merge
          meta_we   = 1'b1;
          meta_addr = bud;
          map_addr  = fm_row(r_r, bud);
          mrow_nxt  = fm_row(r_r, bud);
          mbit_nxt  = fm_bit(r_r, bud);
          mrank_nxt = r_r;
          mset_nxt  = 1'b0;
          ret_nxt   = S_F_LOOP;
          idx_nxt   = (bud < idx_r) ? bud : idx_r;
          r_nxt     = r_r + 5'd1;
          state_nxt = S_MAP_WR;
        end else begin
          meta_we    = 1'b1;
          meta_addr  = idx_r;
          meta_wdata = {1'b0, r_r};
          map_addr   = fm_row(r_r, idx_r);
          mrow_nxt   = fm_row(r_r, idx_r);
          mbit_nxt   = fm_bit(r_r, idx_r);
          mrank_nxt  = r_r;
          mset_nxt   = 1'b1;
          ret_nxt    = S_F_DONE;
          state_nxt  = S_MAP_WR;
        end
      end
      S_F_DONE: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_Q: begin
        meta_addr = qstart;
        state_nxt = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (md.rank == r_r) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
          if (md.busy && (qstart != page_r)) begin
            st = ST_INVALID;
          end else begin
            br = r_r;
          end
        end else if (r_r == RANK_W'(TOP_RANK)) begin
          done      = 1'b1;
          st        = ST_INVALID;
          state_nxt = S_IDLE;
        end else begin
          r_nxt     = r_r + 5'd1;
          state_nxt = S_Q;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pool_len_r  <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < TOP_RANK; k++) fcnt_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      pool_len_r  <= pool_len_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= done;
      if (cnt_clr) begin
        for (int k = 0; k < TOP_RANK; k++) fcnt_r[k] <= '0;
      end else if (cnt_inc) begin
        fcnt_r[cnt_idx] <= fcnt_r[cnt_idx] + cnt_t'(1);
      end else if (cnt_dec) begin
        fcnt_r[cnt_idx] <= fcnt_r[cnt_idx] - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    i_r      <= i_nxt;
    rank_r   <= rank_nxt;
    r_r      <= r_nxt;
    page_r   <= page_nxt;
    idx_r    <= idx_nxt;
    rowptr_r <= rowptr_nxt;
    mrow_r   <= mrow_nxt;
    mbit_r   <= mbit_nxt;
    mrank_r  <= mrank_nxt;
    mset_r   <= mset_nxt;
    if (done) begin
      out_status_r     <= st;
      out_alloc_page_r <= ap;
      out_block_rank_r <= br;
      out_free_count_r <= fc;
    end
  end

  assign busy           = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready      = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_page = out_alloc_page_r;
  assign out_block_rank = out_block_rank_r;
  assign out_free_count = out_free_count_r;
endmodule

### bench/buddy_page_allocator_tb.sv
// Self-checking bench for the buddy page allocator: pool carving, alloc/free/query/count.
`timescale 1ns / 1ps
module buddy_page_allocator_tb;
  import bpa_pkg::*;

  typedef struct {
    logic [1:0] status;
    page_t      alloc_page;
    rank_t      block_rank;
    cnt_t       free_count;
  } answer_t;

  class page_pool_model;
    byte unsigned head_rank[MAX_PAGES];
    bit           busy_mark[MAX_PAGES];
    bit           free_map[2*MAX_PAGES];
    int unsigned  free_blocks[TOP_RANK+1];
    int unsigned  map_base[TOP_RANK+1];
    int unsigned  pool_len;
    int unsigned  held_heads[$];
    answer_t      pending_answers[$];
    int           errors;

    function new();
      int unsigned acc;
      acc = 0;
      errors = 0;
      for (int r = 1; r <= TOP_RANK; r++) begin
        map_base[r] = acc;
        acc += MAX_PAGES >> (r - 1);
      end
      carve(0);
    endfunction

    function void set_free(int unsigned r, int unsigned pg);
      head_rank[pg] = 8'(r);
      busy_mark[pg] = 0;
      free_map[map_base[r] + (pg >> (r - 1))] = 1;
      free_blocks[r]++;
    endfunction

    function void clear_free(int unsigned r, int unsigned pg);
      free_map[map_base[r] + (pg >> (r - 1))] = 0;
      free_blocks[r]--;
      head_rank[pg] = 0;
    endfunction

    function void carve(int unsigned pool);
      int unsigned i, best;
      foreach (head_rank[k]) head_rank[k] = 0;
      foreach (busy_mark[k]) busy_mark[k] = 0;
      foreach (free_map[k]) free_map[k] = 0;
      foreach (free_blocks[k]) free_blocks[k] = 0;
      held_heads.delete();
      pool_len = (pool > MAX_PAGES) ? MAX_PAGES : pool;
      i = 0;
      while (i < pool_len) begin
        best = 1;
        for (int r = TOP_RANK; r >= 1; r--) begin
          if ((i & ((1 << (r - 1)) - 1)) == 0 && i + (1 << (r - 1)) <= pool_len) begin
            best = r;
            break;
          end
        end
        set_free(best, i);
        i += 1 << (best - 1);
      end
    endfunction

    function void note_request(logic [1:0] cmd, rank_t rank, page_t page);
      answer_t a;
      int unsigned r, idx, bud, b, nblk, head, found;
      bit hit;
      a = '{ST_OK, '0, '0, '0};
      case (cmd)
        CMD_ALLOC: begin
          if (rank < 1 || rank > TOP_RANK) a.status = ST_INVALID;
          else begin
            for (r = rank; r <= TOP_RANK; r++) if (free_blocks[r] > 0) break;
            if (pool_len == 0 || r > TOP_RANK) a.status = ST_NOSPACE;
            else begin
              nblk = MAX_PAGES >> (r - 1);
              hit = 0;
              for (b = 0; b < nblk; b++) if (free_map[map_base[r] + b]) begin
                hit = 1;
                break;
              end
              if (!hit) a.status = ST_NOSPACE;
              else begin
                idx = b << (r - 1);
                clear_free(r, idx);
                while (r > rank) begin
                  r--;
                  set_free(r, idx + (1 << (r - 1)));
                end
                head_rank[idx] = 8'(rank);
                busy_mark[idx] = 1;
                held_heads.push_back(idx);
                a.alloc_page = page_t'(idx);
              end
            end
          end
        end
        CMD_FREE: begin
          if (page >= pool_len || head_rank[page] == 0 || !busy_mark[page])
            a.status = ST_INVALID;
          else begin
            idx = page;
            r = head_rank[page];
            head_rank[idx] = 0;
            busy_mark[idx] = 0;
            foreach (held_heads[k]) if (held_heads[k] == page) begin
              held_heads.delete(k);
              break;
            end
            while (r < TOP_RANK) begin
              bud = idx ^ (1 << (r - 1));
              if (bud + (1 << (r - 1)) > pool_len) break;
              if (head_rank[bud] != r || busy_mark[bud]) break;
              clear_free(r, bud);
              if (bud < idx) idx = bud;
              r++;
            end
            set_free(r, idx);
          end
        end
        CMD_QUERY: begin
          if (page >= pool_len) a.status = ST_INVALID;
          else begin
            head = 0;
            found = 0;
            for (r = 1; r <= TOP_RANK; r++) begin
              b = page & ~((1 << (r - 1)) - 1);
              if (head_rank[b] == r) begin
                head = b;
                found = r;
                break;
              end
            end
            if (found == 0 || (busy_mark[head] && head != page)) a.status = ST_INVALID;
            else a.block_rank = rank_t'(found);
          end
        end
        default: begin
          if (rank < 1 || rank > TOP_RANK) a.status = ST_INVALID;
          else a.free_count = cnt_t'(pool_len ? free_blocks[rank] : 0);
        end
      endcase
      pending_answers.push_back(a);
    endfunction

    function void check_result(logic [1:0] st, page_t ap, rank_t br, cnt_t fc);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding: status %0d", st);
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, st);
        errors++;
      end
      if (ap !== a.alloc_page) begin
        $error("alloc_page: expected %0d, got %0d", a.alloc_page, ap);
        errors++;
      end
      if (br !== a.block_rank) begin
        $error("block_rank: expected %0d, got %0d", a.block_rank, br);
        errors++;
      end
      if (fc !== a.free_count) begin
        $error("free_count: expected %0d, got %0d", a.free_count, fc);
        errors++;
      end
    endfunction
  endclass

  logic       clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  logic [1:0] in_command, out_status;
  rank_t      in_rank, out_block_rank;
  page_t      in_page, out_alloc_page;
  cnt_t       out_free_count, cfg_pool_pages;

  page_pool_model pool;
  longint unsigned cycles;

  buddy_page_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_rank(in_rank), .in_page(in_page),
    .out_valid(out_valid), .out_status(out_status), .out_alloc_page(out_alloc_page),
    .out_block_rank(out_block_rank), .out_free_count(out_free_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_pages(cfg_pool_pages)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) pool.check_result(out_status, out_alloc_page, out_block_rank,
                                              out_free_count);
  end

  // the limit allows a full clearing pass per pool write and rank-1 scans of up to 1024 rows
  always @(posedge clk) begin
    cycles++;
    if (cycles > 20_000_000) begin
      $display("buddy_page_allocator_tb: done, errors");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic [1:0] cmd, int unsigned rank, int unsigned page,
                              int unsigned gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command = cmd;
    in_rank    = rank_t'(rank);
    in_page    = page_t'(page);
    start      = 1'b1;
    do @(posedge clk); while (busy);
    pool.note_request(cmd, in_rank, in_page);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_pool(int unsigned pages);
    while (pool.pending_answers.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_pool_pages = cnt_t'(pages);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pool.carve(pages);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int unsigned pick_page();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2 || pool.pool_len == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, pool.pool_len - 1);
  endfunction

  task automatic random_requests(int unsigned n);
    int unsigned sel, rank, gap, top;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if ((i / 40) % 3 == 2) gap = 0;
      top = 1;
      while (top < TOP_RANK && (1 << top) <= pool.pool_len) top++;
      rank = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31)
           : $urandom_range(1, ($urandom_range(0, 3) == 0) ? top : (top < 4 ? top : 4));
      if (sel < 40)
        send_request(CMD_ALLOC, rank, $urandom_range(0, 65535), gap);
      else if (sel < 70 && pool.held_heads.size() > 0)
        send_request(CMD_FREE, $urandom_range(0, 31),
                     pool.held_heads[$urandom_range(0, pool.held_heads.size() - 1)], gap);
      else if (sel < 78)
        send_request(CMD_FREE, $urandom_range(0, 31), pick_page(), gap);
      else if (sel < 90)
        send_request(CMD_QUERY, $urandom_range(0, 31), pick_page(), gap);
      else
        send_request(CMD_COUNT, rank, $urandom_range(0, 65535), gap);
    end
  endtask

  initial begin
    pool = new();
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ALLOC;
    in_rank = '0;
    in_page = '0;
    cfg_valid = 1'b0;
    cfg_pool_pages = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // no pool after reset
    send_request(CMD_ALLOC, 1, 0, 0);
    send_request(CMD_ALLOC, 0, 0, 1);
    send_request(CMD_ALLOC, 17, 0, 0);
    send_request(CMD_COUNT, 1, 0, 2);
    send_request(CMD_COUNT, 31, 0, 0);
    send_request(CMD_FREE, 0, 0, 0);
    send_request(CMD_QUERY, 0, 65535, 0);

    write_pool(100);
    send_request(CMD_ALLOC, 3, 65535, 0);
    send_request(CMD_QUERY, 0, 1, 0);      // inside a free block, not its head
    send_request(CMD_QUERY, 0, 0, 0);
    send_request(CMD_QUERY, 0, 99, 0);
    send_request(CMD_QUERY, 0, 100, 0);
    send_request(CMD_ALLOC, 16, 0, 0);     // no block large enough
    send_request(CMD_ALLOC, 1, 0, 3);
    send_request(CMD_FREE, 0, 5, 0);       // not a head
    send_request(CMD_FREE, 0, 100, 0);     // outside pool
    send_request(CMD_COUNT, 1, 0, 0);
    send_request(CMD_COUNT, 16, 0, 0);
    send_request(CMD_FREE, 31, 4, 0);
    send_request(CMD_FREE, 0, 0, 0);       // head of a free block: rejected
    send_request(CMD_COUNT, 7, 0, 0);
    send_request(CMD_COUNT, 0, 0, 0);
    random_requests(150);

    write_pool(65536);
    random_requests(250);
    write_pool(131071);                    // saturates to the full pool
    random_requests(150);
    write_pool(37);
    random_requests(250);
    write_pool(1000);
    random_requests(200);
    write_pool(1);
    random_requests(80);
    write_pool(65535);
    random_requests(170);
    write_pool(0);
    random_requests(40);

    while (pool.pending_answers.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (pool.errors == 0 && pool.pending_answers.size() == 0)
      $display("buddy_page_allocator_tb: done, clean");
    else
      $display("buddy_page_allocator_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/buddy_page_allocator.sv
bench/buddy_page_allocator_tb.sv
